// ----- src/bounded_double_ended_queue_unit_macros.svh -----
// Assertion macros for the bounded double-ended queue unit.
// Used by the port checker; no other dependencies.
`ifndef BOUNDED_DOUBLE_ENDED_QUEUE_UNIT_MACROS_SVH
`define BOUNDED_DOUBLE_ENDED_QUEUE_UNIT_MACROS_SVH

// Check a property on every rising edge outside of reset.
`define BDQ_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition never holds outside of reset.
`define BDQ_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  `BDQ_ASSERT(lbl, clk, rst_n, !(cond), msg)

`endif

// ----- src/bdq_pkg.sv -----
// Shared types, constants and ring arithmetic for the double-ended queue.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package bdq_pkg;

  localparam int DEPTH      = 64;
  localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int FILL_W     = 7;
  localparam int DATA_W     = 32;
  localparam int CMDQ_DEPTH = 2;
  localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
  localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);
  localparam int RES_DEPTH  = 4;
  localparam int RES_PTR_W  = $clog2(RES_DEPTH);
  localparam int RES_CNT_W  = $clog2(RES_DEPTH + 1);

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef enum logic [2:0] {
    KIND_PUSH_FRONT = 3'd0,
    KIND_PUSH_BACK  = 3'd1,
    KIND_LIST       = 3'd2,
    KIND_POP_FRONT  = 3'd3,
    KIND_POP_BACK   = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_e;

  typedef enum logic {
    BK_IDLE = 1'b0,
    BK_LIST = 1'b1
  } bk_state_e;

  typedef struct packed {
    kind_e                    op;
    logic signed [DATA_W-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] element;
    logic [FILL_W-1:0]        fill;
    status_e                  status;
    logic                     last;
  } res_t;

  // Ring position a + b, with both below DEPTH.
  function automatic idx_t ring_add(input idx_t a, input idx_t b);
    logic [IDX_W:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    if (sum >= (IDX_W+1)'(DEPTH)) begin
      sum = sum - (IDX_W+1)'(DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

  // Ring position one step toward the front.
  function automatic idx_t ring_dec(input idx_t a);
    idx_t r;
    if (a == '0) begin
      r = IDX_W'(DEPTH - 1);
    end else begin
      r = a - IDX_W'(1);
    end
    return r;
  endfunction

endpackage

// ----- src/bounded_double_ended_queue_unit.sv -----
// Bounded double-ended queue of signed 32-bit values, 64 entries.
// Input channel: an operation beat (kind_i, value_i) is taken on a rising edge
//   with push high and full low. Kinds: push front, push back, list, pop front,
//   pop back; undefined kinds are dropped without a result.
// Result channel: the oldest result is on element_o, fill_o, status_o, last_o
//   while empty is low and is taken on a rising edge with pop high.
// Path: command queue, back-end result stage, result queue, then the outputs.
// Throughput: pushes and pops do not hold the back end, so one operation per
//   cycle is sustained while the consumer pops every cycle.
//   A list holds the back end: a start step, then the elements one at a time
//   from the single read port of the ring store (one result when empty).
// Reset: the queue is empty and both internal queues are flushed; the store
//   contents are not cleared and need no sweep.
// Stall: when the consumer holds pop low the result queue fills, the back end
//   stops, then the two-entry command queue fills and full rises.
// Depends on bdq_pkg, bdq_front, bdq_back and bdq_resq.
`timescale 1ns / 1ps

module bounded_double_ended_queue_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                push,
  output logic                                full,
  input  logic [2:0]                          kind_i,
  input  logic signed [bdq_pkg::DATA_W-1:0]   value_i,
  output logic                                empty,
  input  logic                                pop,
  output logic signed [bdq_pkg::DATA_W-1:0]   element_o,
  output logic [bdq_pkg::FILL_W-1:0]          fill_o,
  output logic [1:0]                          status_o,
  output logic                                last_o
);
  import bdq_pkg::*;

  logic                 cmd_valid;
  cmd_t                 cmd;
  logic                 cmd_pop;
  logic [RES_CNT_W-1:0] res_level;
  logic                 res_wr;
  res_t                 res_wr_data;
  res_t                 res_head;

  // Accept and classify operation beats
  bdq_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .kind_i      (kind_i),
    .value_i     (value_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  // Execute against the ring store
  bdq_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .res_level_i (res_level),
    .res_wr_o    (res_wr),
    .res_o       (res_wr_data)
  );

  // Buffer result beats for the consumer
  bdq_resq u_resq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (res_wr),
    .wr_data_i (res_wr_data),
    .pop       (pop),
    .empty     (empty),
    .rd_data_o (res_head),
    .level_o   (res_level)
  );

  assign element_o = res_head.element;
  assign fill_o    = res_head.fill;
  assign status_o  = res_head.status;
  assign last_o    = res_head.last;

endmodule

// ----- src/bdq_front.sv -----
// Front end: decodes incoming operations and holds them in a short command queue.
// Depends on bdq_pkg.
`timescale 1ns / 1ps

module bdq_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push,
  output logic                           full,
  input  logic [2:0]                     kind_i,
  input  logic signed [bdq_pkg::DATA_W-1:0] value_i,
  output logic                           cmd_valid_o,
  output bdq_pkg::cmd_t                  cmd_o,
  input  logic                           cmd_pop_i
);
  import bdq_pkg::*;

  cmd_t                  cmdq_q [CMDQ_DEPTH];
  logic [CMDQ_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [CMDQ_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CMDQ_CNT_W-1:0] cnt_q, cnt_d;
  logic                  known;
  logic                  wr_en;
  logic                  rd_en;
  kind_e                 op;

  // Classify the operation; undefined codes are dropped here
  always_comb begin
    known = 1'b1;
    op    = KIND_PUSH_FRONT;
    unique case (kind_i)
      KIND_PUSH_FRONT: op = KIND_PUSH_FRONT;
      KIND_PUSH_BACK:  op = KIND_PUSH_BACK;
      KIND_LIST:       op = KIND_LIST;
      KIND_POP_FRONT:  op = KIND_POP_FRONT;
      KIND_POP_BACK:   op = KIND_POP_BACK;
      default:         known = 1'b0;
    endcase
  end

  assign full        = (cnt_q == CMDQ_CNT_W'(CMDQ_DEPTH));
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = cmdq_q[rd_ptr_q];
  assign wr_en       = push && !full && known;
  assign rd_en       = cmd_pop_i && cmd_valid_o;

  // Advance pointers and fill level
  always_comb begin
    wr_ptr_d = wr_en ? wr_ptr_q + CMDQ_PTR_W'(1) : wr_ptr_q;
    rd_ptr_d = rd_en ? rd_ptr_q + CMDQ_PTR_W'(1) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (wr_en && !rd_en) begin
      cnt_d = cnt_q + CMDQ_CNT_W'(1);
    end else if (!wr_en && rd_en) begin
      cnt_d = cnt_q - CMDQ_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store the decoded command beat
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      cmdq_q[wr_ptr_q] <= '{op: op, value: value_i};
    end
  end

endmodule

// ----- src/bdq_back.sv -----
// Back end: owns the ring store, front index and count, and executes commands.
// Depends on bdq_pkg.
`timescale 1ns / 1ps

module bdq_back (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cmd_valid_i,
  input  bdq_pkg::cmd_t                   cmd_i,
  output logic                            cmd_pop_o,
  input  logic [bdq_pkg::RES_CNT_W-1:0]   res_level_i,
  output logic                            res_wr_o,
  output bdq_pkg::res_t                   res_o
);
  import bdq_pkg::*;

  logic signed [DATA_W-1:0] ring_q [DEPTH];
  logic signed [DATA_W-1:0] rd_data_q;

  bk_state_e st_q, st_d;
  idx_t      front_q, front_d;
  cnt_t      count_q, count_d;
  idx_t      idx_q, idx_d;

  logic                     mem_we;
  idx_t                     mem_waddr;
  logic signed [DATA_W-1:0] mem_wdata;
  logic                     rd_en;
  idx_t                     rd_addr;

  logic  s2_valid_q, s2_valid_d;
  logic  s2_mem_q, s2_mem_d;
  res_t  s2_res_q, s2_res_d;

  logic  room;
  logic  is_full;
  logic  is_empty;
  logic  list_last;

  // Reserve a result slot for the beat already in flight
  assign room = ({1'b0, res_level_i} + {{RES_CNT_W{1'b0}}, s2_valid_q})
                < (RES_CNT_W+1)'(RES_DEPTH);
  assign is_full   = (count_q == CNT_W'(DEPTH));
  assign is_empty  = (count_q == '0);
  assign list_last = ((CNT_W'(idx_q) + CNT_W'(1)) == count_q);

  // Sequence commands against the ring
  always_comb begin
    st_d       = st_q;
    front_d    = front_q;
    count_d    = count_q;
    idx_d      = idx_q;
    cmd_pop_o  = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = front_q;
    mem_wdata  = cmd_i.value;
    rd_en      = 1'b0;
    rd_addr    = front_q;
    s2_valid_d = 1'b0;
    s2_mem_d   = 1'b0;
    s2_res_d   = '{element: '0, fill: FILL_W'(count_q), status: STAT_OK, last: 1'b1};

    unique case (st_q)
      BK_IDLE: begin
        if (cmd_valid_i && room) begin
          cmd_pop_o = 1'b1;
          case (cmd_i.op) inside
            KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
              s2_valid_d = 1'b1;
              if (is_full) begin
                s2_res_d.status = STAT_FULL;
              end else begin
                mem_we = 1'b1;
                if (cmd_i.op == KIND_PUSH_FRONT) begin
                  front_d   = ring_dec(front_q);
                  mem_waddr = ring_dec(front_q);
                end else begin
                  mem_waddr = ring_add(front_q, IDX_W'(count_q));
                end
                count_d       = count_q + CNT_W'(1);
                s2_res_d.fill = FILL_W'(count_q + CNT_W'(1));
              end
            end
            KIND_POP_FRONT, KIND_POP_BACK: begin
              s2_valid_d = 1'b1;
              if (is_empty) begin
                s2_res_d.status = STAT_EMPTY;
              end else begin
                rd_en    = 1'b1;
                s2_mem_d = 1'b1;
                if (cmd_i.op == KIND_POP_FRONT) begin
                  rd_addr = front_q;
                  front_d = ring_add(front_q, IDX_W'(1));
                end else begin
                  rd_addr = ring_add(front_q, IDX_W'(count_q - CNT_W'(1)));
                end
                count_d       = count_q - CNT_W'(1);
                s2_res_d.fill = FILL_W'(count_q - CNT_W'(1));
              end
            end
            KIND_LIST: begin
              if (is_empty) begin
                s2_valid_d      = 1'b1;
                s2_res_d.status = STAT_EMPTY;
              end else begin
                st_d  = BK_LIST;
                idx_d = '0;
              end
            end
            default: begin
              s2_valid_d = 1'b0;
            end
          endcase
        end
      end
      BK_LIST: begin
        // Walk one held element per beat, front to back
        if (room) begin
          rd_en         = 1'b1;
          rd_addr       = ring_add(front_q, idx_q);
          s2_valid_d    = 1'b1;
          s2_mem_d      = 1'b1;
          s2_res_d.last = list_last;
          if (list_last) begin
            st_d = BK_IDLE;
          end else begin
            idx_d = idx_q + IDX_W'(1);
          end
        end
      end
      default: begin
        st_d = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q       <= BK_IDLE;
      front_q    <= '0;
      count_q    <= '0;
      idx_q      <= '0;
      s2_valid_q <= 1'b0;
      s2_mem_q   <= 1'b0;
    end else begin
      st_q       <= st_d;
      front_q    <= front_d;
      count_q    <= count_d;
      idx_q      <= idx_d;
      s2_valid_q <= s2_valid_d;
      s2_mem_q   <= s2_mem_d;
    end
  end

  // Hold the result fields for the write-back stage
  always_ff @(posedge clk_i) begin
    s2_res_q <= s2_res_d;
  end

  // Ring store with registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      ring_q[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rd_data_q <= ring_q[rd_addr];
    end
  end

  // Merge read data into the result beat
  always_comb begin
    res_o = s2_res_q;
    if (s2_mem_q) begin
      res_o.element = rd_data_q;
    end
  end
  assign res_wr_o = s2_valid_q;

endmodule

// ----- src/bdq_resq.sv -----
// Result queue: buffers finished result beats for the consumer.
// Depends on bdq_pkg.
`timescale 1ns / 1ps

module bdq_resq (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          wr_i,
  input  bdq_pkg::res_t                 wr_data_i,
  input  logic                          pop,
  output logic                          empty,
  output bdq_pkg::res_t                 rd_data_o,
  output logic [bdq_pkg::RES_CNT_W-1:0] level_o
);
  import bdq_pkg::*;

  res_t                 buf_q [RES_DEPTH];
  logic [RES_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [RES_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [RES_CNT_W-1:0] cnt_q, cnt_d;
  logic                 rd_en;

  assign empty     = (cnt_q == '0);
  assign rd_data_o = buf_q[rd_ptr_q];
  assign level_o   = cnt_q;
  assign rd_en     = pop && !empty;

  // Advance pointers; the back end never writes into a full queue
  always_comb begin
    wr_ptr_d = wr_i ? wr_ptr_q + RES_PTR_W'(1) : wr_ptr_q;
    rd_ptr_d = rd_en ? rd_ptr_q + RES_PTR_W'(1) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (wr_i && !rd_en) begin
      cnt_d = cnt_q + RES_CNT_W'(1);
    end else if (!wr_i && rd_en) begin
      cnt_d = cnt_q - RES_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      buf_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

// ----- src/bdq_checker.sv -----
// Port-level checker for the double-ended queue, bound to the top level.
// Depends on bdq_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "bounded_double_ended_queue_unit_macros.svh"

module bdq_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              empty,
  input logic                              pop,
  input logic signed [bdq_pkg::DATA_W-1:0] element_o,
  input logic [bdq_pkg::FILL_W-1:0]        fill_o,
  input logic [1:0]                        status_o,
  input logic                              last_o
);
  import bdq_pkg::*;

  logic                           code_ok;
  logic                           head_full;
  logic                           head_empty;
  logic                           head_held;
  logic                           full_beat_ok;
  logic                           empty_beat_ok;
  logic [DATA_W+FILL_W+2:0]       head_val;

  // Classify the waiting result beat
  assign code_ok       = (status_o == STAT_OK) || (status_o == STAT_EMPTY) ||
                         (status_o == STAT_FULL);
  assign head_full     = !empty && (status_o == STAT_FULL);
  assign head_empty    = !empty && (status_o == STAT_EMPTY);
  assign head_held     = !empty && !pop;
  assign full_beat_ok  = (fill_o == FILL_W'(DEPTH)) && (element_o == '0) && last_o;
  assign empty_beat_ok = (fill_o == '0) && (element_o == '0) && last_o;
  assign head_val      = {element_o, fill_o, status_o, last_o};

  // Only defined status codes leave the block
  `BDQ_ASSERT_NEVER(a_status_code, clk_i, rst_ni, !empty && !code_ok, "bad status")

  // A refused push reports a full store and nothing else
  `BDQ_ASSERT(a_full_beat, clk_i, rst_ni, head_full |-> full_beat_ok, "bad full beat")

  // An empty status reports zero fill, zero element, single beat
  `BDQ_ASSERT(a_empty_beat, clk_i, rst_ni, head_empty |-> empty_beat_ok, "bad empty beat")

  // A stalled result holds
  `BDQ_ASSERT(a_hold, clk_i, rst_ni, head_held |=> !empty && $stable(head_val), "result moved")

endmodule

bind bounded_double_ended_queue_unit bdq_checker u_bdq_checker (.*);
